### hdl/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix sorter package
// Shared key width and the sequencer state type of the descending radix sorter.
// ----------------------------------------------------------------------------
package rsd_pkg;

   // Width of one key.
   localparam int KEY_W = 32;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_COUNT,
      ST_SUFFIX,
      ST_SCATTER,
      ST_OUT_READ,
      ST_OUT_SHOW
   } state_type;

endpackage

### hdl/rsd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix sorter request channel
// Valid/ready channel that carries one key and its end-of-set mark per item.
// ----------------------------------------------------------------------------
interface rsd_req_if;
   logic                     valid;
   logic                     ready;
   logic [rsd_pkg::KEY_W-1:0] key;
   logic                     is_last;

   modport source (output valid, output key, output is_last, input ready);
   modport sink   (input valid, input key, input is_last, output ready);
endinterface

### hdl/rsd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix sorter response channel
// Valid/ready channel that carries one sorted key and its status flags per item.
// ----------------------------------------------------------------------------
interface rsd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [rsd_pkg::KEY_W-1:0] sorted_key;
   logic                     is_final;
   logic                     overflowed;

   modport source (output valid, output sorted_key, output is_final, output overflowed,
                   input ready);
   modport sink   (input valid, input sorted_key, input is_final, input overflowed,
                   output ready);
endinterface

### hdl/radix_sort_descending_u32.sv
`timescale 1ns / 1ps
// Sorting starts once the item marked last has been accepted.
// Throughput: keys load at one per cycle; each sorted key is read from the final key
// buffer before it is offered, so a new key is not shown until the last one is taken.
// Reset: synchronous; the set is emptied and the overflow flag is cleared.
// ----------------------------------------------------------------------------
// Descending radix sorter for unsigned 32-bit keys
// Loads a set of keys, sorts it with a stable LSD radix sort held in block
// memories (two key buffers and a digit histogram) and streams it out.
// ----------------------------------------------------------------------------
module radix_sort_descending_u32 #(
   parameter int MAX_COUNT  = 64,
   parameter int DIGIT_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   rsd_req_if.sink         req_ch,
   rsd_rsp_if.source       rsp_ch
);

   localparam int KW         = rsd_pkg::KEY_W;
   localparam int AW         = $clog2(MAX_COUNT);
   localparam int CW         = $clog2(MAX_COUNT + 1);
   localparam int BUCKETS    = 1 << DIGIT_BITS;
   localparam int PASSES     = (KW + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PW         = $clog2(PASSES);
   localparam bit FINAL_IN_B = (PASSES % 2) == 1;

   // Sequencer and set bookkeeping.
   rsd_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic                   drop_ff, drop_in;
   logic [PW-1:0]          pass_ff, pass_in;
   logic [DIGIT_BITS-1:0]  sweep_ff, sweep_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          acc_ff, acc_in;
   logic [CW-1:0]          out_idx_ff, out_idx_in;

   // Key pipeline for counting and scattering.
   logic                   s1_vld_ff, s1_vld_in;
   logic                   s2_vld_ff, s2_vld_in;
   logic [DIGIT_BITS-1:0]  s2_dig_ff, s2_dig_in;
   logic [KW-1:0]          s2_key_ff, s2_key_in;
   logic                   fwd_vld_ff, fwd_vld_in;
   logic [DIGIT_BITS-1:0]  fwd_dig_ff, fwd_dig_in;
   logic [CW-1:0]          fwd_val_ff, fwd_val_in;

   // Suffix sum pipeline.
   logic                   sfx_vld_ff, sfx_vld_in;
   logic [DIGIT_BITS-1:0]  sfx_dig_ff, sfx_dig_in;

   // Memory ports.
   logic                   a_wr_en, a_rd_en, b_wr_en, b_rd_en;
   logic [AW-1:0]          a_wr_addr, a_rd_addr, b_wr_addr, b_rd_addr;
   logic [KW-1:0]          a_wr_data, b_wr_data, a_rd_data, b_rd_data;
   logic                   h_wr_en, h_rd_en;
   logic [DIGIT_BITS-1:0]  h_wr_addr, h_rd_addr;
   logic [CW-1:0]          h_wr_data, h_rd_data;

   // Shared decoded signals.
   logic                   req_acc, rsp_acc, room;
   logic                   issue, walk_done, sfx_done, last_pass, last_out;
   logic                   src_is_b;
   logic [CW-1:0]          rev_idx;
   logic [AW-1:0]          src_addr;
   logic [KW-1:0]          src_rd_data, shifted;
   logic [4:0]             shift_amt;
   logic [DIGIT_BITS-1:0]  digit1;
   logic [CW-1:0]          base, newv, sum;

   // Key buffers and the digit histogram.
   rsd_ram #(.WIDTH(KW), .DEPTH(MAX_COUNT)) u_buf_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   rsd_ram #(.WIDTH(KW), .DEPTH(MAX_COUNT)) u_buf_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   rsd_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_hist (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // Handshakes and phase conditions.
   always_comb begin
      req_acc   = req_ch.valid && req_ch.ready;
      rsp_acc   = rsp_ch.valid && rsp_ch.ready;
      room      = fill_ff != CW'(MAX_COUNT);
      issue     = ((state_ff == rsd_pkg::ST_COUNT) || (state_ff == rsd_pkg::ST_SCATTER))
                  && (idx_ff != fill_ff);
      walk_done = (idx_ff == fill_ff) && !s1_vld_ff && !s2_vld_ff;
      sfx_done  = sfx_vld_ff && (sfx_dig_ff == '0);
      last_pass = pass_ff == PW'(PASSES - 1);
      last_out  = out_idx_ff == (fill_ff - CW'(1));
   end

   // Source buffer selection and digit extraction. Even passes read buffer A.
   always_comb begin
      src_is_b    = pass_ff[0];
      rev_idx     = fill_ff - idx_ff - CW'(1);
      src_addr    = (state_ff == rsd_pkg::ST_COUNT) ? idx_ff[AW-1:0] : rev_idx[AW-1:0];
      src_rd_data = src_is_b ? b_rd_data : a_rd_data;
      shift_amt   = 5'(pass_ff * DIGIT_BITS);
      shifted     = src_rd_data >> shift_amt;
      digit1      = shifted[DIGIT_BITS-1:0];
   end

   // Histogram update value, with the previous cycle's write forwarded, and the suffix sum.
   always_comb begin
      base = (fwd_vld_ff && (fwd_dig_ff == s2_dig_ff)) ? fwd_val_ff : h_rd_data;
      newv = (state_ff == rsd_pkg::ST_COUNT) ? base + CW'(1) : base - CW'(1);
      sum  = acc_ff + h_rd_data;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsd_pkg::ST_LOAD: begin
            if (req_acc && req_ch.is_last) begin
               state_in = rsd_pkg::ST_CLEAR;
            end
         end
         rsd_pkg::ST_CLEAR: begin
            if (sweep_ff == '1) begin
               state_in = rsd_pkg::ST_COUNT;
            end
         end
         rsd_pkg::ST_COUNT: begin
            if (walk_done) begin
               state_in = rsd_pkg::ST_SUFFIX;
            end
         end
         rsd_pkg::ST_SUFFIX: begin
            if (sfx_done) begin
               state_in = rsd_pkg::ST_SCATTER;
            end
         end
         rsd_pkg::ST_SCATTER: begin
            if (walk_done) begin
               state_in = last_pass ? rsd_pkg::ST_OUT_READ : rsd_pkg::ST_CLEAR;
            end
         end
         rsd_pkg::ST_OUT_READ: begin
            state_in = rsd_pkg::ST_OUT_SHOW;
         end
         rsd_pkg::ST_OUT_SHOW: begin
            if (rsp_acc) begin
               state_in = last_out ? rsd_pkg::ST_LOAD : rsd_pkg::ST_OUT_READ;
            end
         end
         default: begin
            state_in = rsd_pkg::ST_LOAD;
         end
      endcase
   end

   // Handshake and memory port outputs.
   always_comb begin
      req_ch.ready      = state_ff == rsd_pkg::ST_LOAD;
      rsp_ch.valid      = state_ff == rsd_pkg::ST_OUT_SHOW;
      rsp_ch.sorted_key = FINAL_IN_B ? b_rd_data : a_rd_data;
      rsp_ch.is_final   = last_out;
      rsp_ch.overflowed = drop_ff;

      // Buffer A takes loaded keys, and scattered keys on odd passes.
      if (state_ff == rsd_pkg::ST_LOAD) begin
         a_wr_en   = req_acc && room;
         a_wr_addr = fill_ff[AW-1:0];
         a_wr_data = req_ch.key;
      end else begin
         a_wr_en   = (state_ff == rsd_pkg::ST_SCATTER) && s2_vld_ff && src_is_b;
         a_wr_addr = newv[AW-1:0];
         a_wr_data = s2_key_ff;
      end
      b_wr_en   = (state_ff == rsd_pkg::ST_SCATTER) && s2_vld_ff && !src_is_b;
      b_wr_addr = newv[AW-1:0];
      b_wr_data = s2_key_ff;

      // Key reads for the walks and for the output stream.
      if (state_ff == rsd_pkg::ST_OUT_READ) begin
         a_rd_en   = !FINAL_IN_B;
         b_rd_en   = FINAL_IN_B;
         a_rd_addr = out_idx_ff[AW-1:0];
         b_rd_addr = out_idx_ff[AW-1:0];
      end else begin
         a_rd_en   = issue && !src_is_b;
         b_rd_en   = issue && src_is_b;
         a_rd_addr = src_addr;
         b_rd_addr = src_addr;
      end

      // Histogram ports.
      case (state_ff)
         rsd_pkg::ST_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = sweep_ff;
            h_wr_data = '0;
            h_rd_en   = 1'b0;
            h_rd_addr = sweep_ff;
         end
         rsd_pkg::ST_SUFFIX: begin
            h_wr_en   = sfx_vld_ff;
            h_wr_addr = sfx_dig_ff;
            h_wr_data = sum;
            h_rd_en   = !sfx_done;
            h_rd_addr = sweep_ff;
         end
         rsd_pkg::ST_COUNT, rsd_pkg::ST_SCATTER: begin
            h_wr_en   = s2_vld_ff;
            h_wr_addr = s2_dig_ff;
            h_wr_data = newv;
            h_rd_en   = s1_vld_ff;
            h_rd_addr = digit1;
         end
         default: begin
            h_wr_en   = 1'b0;
            h_wr_addr = s2_dig_ff;
            h_wr_data = newv;
            h_rd_en   = 1'b0;
            h_rd_addr = digit1;
         end
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      fill_in    = fill_ff;
      drop_in    = drop_ff;
      pass_in    = pass_ff;
      sweep_in   = '0;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      out_idx_in = out_idx_ff;

      s1_vld_in  = issue;
      s2_vld_in  = s1_vld_ff;
      s2_dig_in  = digit1;
      s2_key_in  = src_rd_data;
      fwd_vld_in = s2_vld_ff;
      fwd_dig_in = s2_dig_ff;
      fwd_val_in = newv;

      sfx_vld_in = (state_ff == rsd_pkg::ST_SUFFIX) && !sfx_done;
      sfx_dig_in = sweep_ff;

      case (state_ff)
         rsd_pkg::ST_LOAD: begin
            out_idx_in = '0;
            if (req_acc) begin
               if (room) begin
                  fill_in = fill_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         rsd_pkg::ST_CLEAR: begin
            sweep_in = sweep_ff + DIGIT_BITS'(1);
            idx_in   = '0;
            acc_in   = '0;
         end
         rsd_pkg::ST_COUNT: begin
            sweep_in = '1;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         rsd_pkg::ST_SUFFIX: begin
            sweep_in = sweep_ff - DIGIT_BITS'(1);
            idx_in   = '0;
            if (sfx_vld_ff) begin
               acc_in = sum;
            end
         end
         rsd_pkg::ST_SCATTER: begin
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (walk_done) begin
               pass_in = last_pass ? '0 : pass_ff + PW'(1);
            end
         end
         rsd_pkg::ST_OUT_SHOW: begin
            if (rsp_acc) begin
               out_idx_in = out_idx_ff + CW'(1);
               if (last_out) begin
                  fill_in = '0;
                  drop_in = 1'b0;
               end
            end
         end
         default: begin
            sweep_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rsd_pkg::ST_LOAD;
         fill_ff    <= '0;
         drop_ff    <= 1'b0;
         pass_ff    <= '0;
         sweep_ff   <= '0;
         idx_ff     <= '0;
         acc_ff     <= '0;
         out_idx_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         sfx_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         drop_ff    <= drop_in;
         pass_ff    <= pass_in;
         sweep_ff   <= sweep_in;
         idx_ff     <= idx_in;
         acc_ff     <= acc_in;
         out_idx_ff <= out_idx_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         sfx_vld_ff <= sfx_vld_in;
      end
   end

   // Payload registers of the pipelines.
   always_ff @(posedge clock) begin
      s2_dig_ff  <= s2_dig_in;
      s2_key_ff  <= s2_key_in;
      fwd_dig_ff <= fwd_dig_in;
      fwd_val_ff <= fwd_val_in;
      sfx_dig_ff <= sfx_dig_in;
   end

endmodule

### hdl/rsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port that returns the old contents on a collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
